/* hdl/adsr_et_pkg.sv */
// ----------------------------------------------------------------------------
// adsr_et_pkg
// Shared types and constants for the ADSR envelope table.
// ----------------------------------------------------------------------------
package adsr_et_pkg;

    // default channel count of the table
    localparam int CHANNELS_DEF = 16;

    // operation codes carried in tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // envelope modes, flag bits 2:1
    localparam logic [1:0] MODE_ATTACK  = 2'd0;
    localparam logic [1:0] MODE_DECAY   = 2'd1;
    localparam logic [1:0] MODE_SUSTAIN = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    // flag bit positions
    localparam int F_ACTIVE  = 0;
    localparam int F_MODE_LO = 1;
    localparam int F_MODE_HI = 2;
    localparam int F_KEYOFF  = 4;
    localparam int F_SLIDE   = 5;
    localparam int F_DIRTY   = 7;

    // level limits
    localparam logic [15:0] HIGH_LIMIT    = 16'hfeff;
    localparam logic [15:0] HIGH_CLAMP    = 16'hff00;
    localparam logic [15:0] RELEASE_FLOOR = 16'h00ff;
    localparam logic [15:0] SLIDE_FLOOR   = 16'h0100;
    localparam logic [15:0] MASK_COARSE   = 16'hf000;
    localparam logic [15:0] MASK_FINE     = 16'hff00;

    localparam int ENTRY_W = 24;

    typedef struct packed {
        logic [7:0]  flags;
        logic [15:0] level;
    } entry_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         channel;
        logic [15:0]        level_in;
        logic [7:0]         flags_in;
        logic [15:0]        attack_step;
        logic [15:0]        decay_step;
        logic [15:0]        sustain_level;
        logic [15:0]        release_step;
        logic signed [16:0] slide_delta;
        logic               coarse_mask;
    } item_t;

endpackage

/* hdl/adsr_envelope_table_top.sv */
// ----------------------------------------------------------------------------
// adsr_envelope_table_top
// ADSR envelope table: per-channel level and flags with write, tick, read.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis (tuser = opcode, tdata = channel and step
//   arguments). Each accepted word yields exactly one output word on m_axis
//   carrying the channel's level and flags after the operation.
//   Write loads a channel, tick advances its envelope by one step, read
//   returns it unchanged. A channel index at or beyond CHANNELS changes
//   nothing and returns zero.
// Timing:
//   The entry is read from the table RAM on the accepting edge, modified while
//   the word sits in stage 1 and written back while the result is
//   registered. One word per cycle is sustained while m_axis_tready stays
//   high; a word hitting the channel just updated takes the new entry
//   through a forwarding register instead of the RAM port.
// Reset:
//   rst_n clears every channel at once through per-channel valid bits; an
//   entry never written since reset reads as zero. No clearing pass.
// Stall:
//   When m_axis_tready is low the output register holds, the stage behind it
//   holds its word, and s_axis_tready drops once that stage is occupied.
// ----------------------------------------------------------------------------
module adsr_envelope_table_top
    import adsr_et_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: channel[3:0], level_in[19:4], flags_in[27:20],
    // attack_step[43:28], decay_step[59:44], sustain_level[75:60],
    // release_step[91:76], slide_delta[108:92], coarse_mask[109], zero pad
    input  logic [111:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: level_out[15:0], flags_out[23:16]
    output logic [23:0]  m_axis_tdata
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    item_t         in_item;
    logic          in_accept;

    // stage 1: word waiting on the RAM read
    logic          s1_valid_reg;
    logic          s1_valid_next;
    item_t         s1_item_reg;
    logic          s1_adv;
    logic          s1_in_range;
    logic [AW-1:0] s1_addr;

    // forwarding of the entry just written
    logic          fwd_reg;
    logic          fwd_next;
    entry_t        fwd_data_reg;

    logic [CHANNELS-1:0] valid_reg;
    logic [CHANNELS-1:0] valid_next;

    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    entry_t             old_entry;
    entry_t             new_entry;
    entry_t             result;

    logic          out_valid_reg;
    logic          out_valid_next;
    entry_t        out_data_reg;

    // unpack the input word
    assign in_item.opcode        = s_axis_tuser;
    assign in_item.channel       = s_axis_tdata[3:0];
    assign in_item.level_in      = s_axis_tdata[19:4];
    assign in_item.flags_in      = s_axis_tdata[27:20];
    assign in_item.attack_step   = s_axis_tdata[43:28];
    assign in_item.decay_step    = s_axis_tdata[59:44];
    assign in_item.sustain_level = s_axis_tdata[75:60];
    assign in_item.release_step  = s_axis_tdata[91:76];
    assign in_item.slide_delta   = $signed(s_axis_tdata[108:92]);
    assign in_item.coarse_mask   = s_axis_tdata[109];

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign s1_addr     = AW'(s1_item_reg.channel);
    assign s1_in_range = (32'(s1_item_reg.channel) < CHANNELS);

    // old entry: forwarded, stored, or reset value
    always_comb
    begin
        if (fwd_reg)
        begin
            old_entry = fwd_data_reg;
        end
        else if (s1_in_range && valid_reg[s1_addr])
        begin
            old_entry = entry_t'(ram_rdata);
        end
        else
        begin
            old_entry = '0;
        end
    end

    adsr_et_alu u_alu (
        .item      (s1_item_reg),
        .old_entry (old_entry),
        .new_entry (new_entry)
    );

    assign result = s1_in_range ? new_entry : '0;
    assign ram_we = s1_adv && s1_in_range
                 && ((s1_item_reg.opcode == OP_WRITE) || (s1_item_reg.opcode == OP_TICK));

    adsr_et_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (new_entry),
        .re    (in_accept),
        .raddr (AW'(in_item.channel)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        fwd_next       = fwd_reg;
        out_valid_next = out_valid_reg;
        valid_next     = valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            s1_valid_next  = 1'b0;
            fwd_next       = 1'b0;
            out_valid_next = 1'b1;
        end
        if (ram_we)
        begin
            valid_next[s1_addr] = 1'b1;
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            fwd_next      = s1_adv && (in_item.channel == s1_item_reg.channel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            fwd_data_reg <= result;
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.flags, out_data_reg.level};

    // table is written only when the stage hands its word on
    a_we_on_adv : assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> s1_adv)
        else $error("table write without stage advance");

    // forwarding is only armed for a word in the stage
    a_fwd_stage : assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag set with empty stage");

    // a stalled output keeps the stage word back
    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_axis_tready) |=> s1_valid_reg)
        else $error("stage word lost under stall");

    // a read never modifies the table
    a_read_no_write : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_item_reg.opcode == OP_READ)) |-> !ram_we)
        else $error("read item wrote the table");

endmodule

/* hdl/adsr_et_ram.sv */
// ----------------------------------------------------------------------------
// adsr_et_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adsr_et_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/adsr_et_alu.sv */
// ----------------------------------------------------------------------------
// adsr_et_alu
// Next-entry logic: write, read, tick step and dirty marking for one channel.
// ----------------------------------------------------------------------------
module adsr_et_alu
    import adsr_et_pkg::*;
(
    input  item_t  item,
    input  entry_t old_entry,
    output entry_t new_entry
);

    logic [16:0]        sum_atk;
    logic signed [17:0] dif_dec;
    logic signed [17:0] dif_rel;
    logic signed [17:0] sum_sld;
    logic [15:0]        rel_level;
    logic               rel_done;
    logic [15:0]        dmask;
    logic [15:0]        lvl;
    logic [7:0]         fl;
    logic               ticked;

    assign sum_atk = {1'b0, old_entry.level} + {1'b0, item.attack_step};
    assign dif_dec = $signed({2'b00, old_entry.level}) - $signed({2'b00, item.decay_step});
    assign dif_rel = $signed({2'b00, old_entry.level}) - $signed({2'b00, item.release_step});
    assign sum_sld = $signed({2'b00, old_entry.level})
                   + $signed({item.slide_delta[16], item.slide_delta});

    assign rel_done  = (dif_rel <= $signed({2'b00, RELEASE_FLOOR}));
    assign rel_level = rel_done ? 16'h0000 : dif_rel[15:0];
    assign dmask     = item.coarse_mask ? MASK_COARSE : MASK_FINE;

    always_comb
    begin
        lvl    = old_entry.level;
        fl     = old_entry.flags;
        ticked = 1'b0;
        case (item.opcode)
            OP_WRITE:
            begin
                lvl = item.level_in;
                fl  = item.flags_in;
            end
            OP_TICK:
            begin
                if (fl[F_ACTIVE])
                begin
                    ticked = 1'b1;
                    case (fl[F_MODE_HI:F_MODE_LO])
                        MODE_ATTACK:
                        begin
                            if (sum_atk > {1'b0, HIGH_LIMIT})
                            begin
                                lvl = HIGH_CLAMP;
                                fl[F_MODE_HI:F_MODE_LO] = MODE_DECAY;
                            end
                            else
                            begin
                                lvl = sum_atk[15:0];
                            end
                        end
                        MODE_DECAY:
                        begin
                            if (dif_dec <= $signed({2'b00, item.sustain_level}))
                            begin
                                lvl = item.sustain_level;
                                fl[F_MODE_HI:F_MODE_LO] = MODE_SUSTAIN;
                            end
                            else
                            begin
                                lvl = dif_dec[15:0];
                            end
                        end
                        MODE_SUSTAIN:
                        begin
                            // key-off enters release and steps at once
                            if (fl[F_KEYOFF])
                            begin
                                lvl = rel_level;
                                fl[F_MODE_HI:F_MODE_LO] = MODE_RELEASE;
                                if (rel_done)
                                begin
                                    fl[F_MODE_HI:F_ACTIVE] = 3'b000;
                                end
                            end
                        end
                        default:
                        begin
                            lvl = rel_level;
                            if (rel_done)
                            begin
                                fl[F_MODE_HI:F_ACTIVE] = 3'b000;
                            end
                        end
                    endcase
                end
                else if (fl[F_SLIDE])
                begin
                    ticked = 1'b1;
                    lvl    = sum_sld[15:0];
                    if (!item.slide_delta[16])
                    begin
                        if (sum_sld > $signed({2'b00, HIGH_LIMIT}))
                        begin
                            lvl           = HIGH_CLAMP;
                            fl[F_ACTIVE] = 1'b0;
                            fl[F_SLIDE]  = 1'b0;
                        end
                    end
                    else if (sum_sld <= $signed({2'b00, SLIDE_FLOOR}))
                    begin
                        lvl           = 16'h0000;
                        fl[F_ACTIVE] = 1'b0;
                        fl[F_SLIDE]  = 1'b0;
                    end
                end
                if (ticked && ((lvl & dmask) != (old_entry.level & dmask)))
                begin
                    fl[F_DIRTY] = 1'b1;
                end
            end
            default:
            begin
                // read, and the spare code acting as read
                lvl = old_entry.level;
            end
        endcase
        new_entry.level = lvl;
        new_entry.flags = fl;
    end

endmodule
